>>> rtl/core/xcs_pkg.sv
package xcs_pkg;

  localparam int unsigned BlockBytes = 128;
  localparam int unsigned FrameWords = (BlockBytes + 4) / 4;
  localparam int unsigned FillW      = $clog2(BlockBytes + 1);
  localparam int unsigned WordW      = $clog2(FrameWords);
  localparam int unsigned RowDepth   = BlockBytes / 4;
  localparam int unsigned RowW       = $clog2(RowDepth);

  localparam logic [7:0] RetryLimitRst = 8'd16;
  localparam logic [7:0] BlockNumRst   = 8'd1;

  localparam logic [7:0] ByteSoh = 8'h01;
  localparam logic [7:0] ByteEot = 8'h04;
  localparam logic [7:0] ByteAck = 8'h06;
  localparam logic [7:0] ByteNak = 8'h15;
  localparam logic [7:0] ByteCan = 8'h18;

  typedef enum logic [1:0] {
    KindImage   = 2'd0,
    KindEnd     = 2'd1,
    KindResp    = 2'd2,
    KindTimeout = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StatSending  = 3'd0,
    StatFinished = 3'd1,
    StatNakLimit = 3'd2,
    StatCanceled = 3'd3,
    StatTimeout  = 3'd4,
    StatPhase    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    StFill,
    StWait,
    StDone,
    StFail,
    StRead,
    StPush
  } state_e;

  typedef struct packed {
    logic    wr_byte;
    logic    start_frame;
    logic    final_blk;
    logic    clr_block;
    logic    dec_resend;
    logic    clr_final;
    logic    word_clr;
    logic    read_en;
    logic    push_frame;
    logic    push_status;
    logic    eot;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_empty;
    logic final_pending;
    logic resends_zero;
    logic word_last;
    logic out_busy;
    logic can_load;
  } stat_t;

endpackage

>>> rtl/core/xcs_ctrl.sv
module xcs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_kind_i,
  input  logic [7:0]          in_byte_value_i,
  output logic                in_stall_o,
  input  xcs_pkg::stat_t      stat_i,
  output xcs_pkg::cmd_t       cmd_o
);

  xcs_pkg::state_e state_q, state_d;
  xcs_pkg::kind_e  kind;
  logic            idle;
  logic            acc;

  assign kind       = xcs_pkg::kind_e'(in_kind_i);
  assign idle       = state_q inside {xcs_pkg::StFill, xcs_pkg::StWait,
                                      xcs_pkg::StDone, xcs_pkg::StFail};
  assign in_stall_o = !idle || stat_i.out_busy;
  assign acc        = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xcs_pkg::StFill;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      xcs_pkg::StFill: begin
        if (acc) begin
          case (kind)
            xcs_pkg::KindImage: begin
              if (stat_i.fill_last) state_d = xcs_pkg::StRead;
            end
            xcs_pkg::KindEnd: begin
              state_d = stat_i.fill_empty ? xcs_pkg::StDone : xcs_pkg::StRead;
            end
            default: state_d = state_q;
          endcase
        end
      end
      xcs_pkg::StWait: begin
        if (acc) begin
          if (kind == xcs_pkg::KindTimeout) begin
            state_d = xcs_pkg::StFail;
          end else if (kind == xcs_pkg::KindResp) begin
            case (in_byte_value_i)
              xcs_pkg::ByteAck: begin
                state_d = stat_i.final_pending ? xcs_pkg::StDone : xcs_pkg::StFill;
              end
              xcs_pkg::ByteNak: begin
                state_d = stat_i.resends_zero ? xcs_pkg::StFail : xcs_pkg::StRead;
              end
              xcs_pkg::ByteCan: state_d = xcs_pkg::StFail;
              default:          state_d = state_q;
            endcase
          end
        end
      end
      xcs_pkg::StRead: state_d = xcs_pkg::StPush;
      xcs_pkg::StPush: begin
        if (stat_i.can_load) begin
          state_d = stat_i.word_last ? xcs_pkg::StWait : xcs_pkg::StRead;
        end
      end
      default: state_d = state_q;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = xcs_pkg::StatSending;
    case (state_q)
      xcs_pkg::StFill: begin
        if (acc) begin
          case (kind)
            xcs_pkg::KindImage: begin
              cmd_o.wr_byte = 1'b1;
              if (stat_i.fill_last) begin
                cmd_o.start_frame = 1'b1;
                cmd_o.word_clr    = 1'b1;
              end
            end
            xcs_pkg::KindEnd: begin
              if (stat_i.fill_empty) begin
                cmd_o.push_status = 1'b1;
                cmd_o.eot         = 1'b1;
                cmd_o.status      = xcs_pkg::StatFinished;
              end else begin
                cmd_o.start_frame = 1'b1;
                cmd_o.final_blk   = 1'b1;
                cmd_o.word_clr    = 1'b1;
              end
            end
            default: begin
              cmd_o.push_status = 1'b1;
              cmd_o.status      = xcs_pkg::StatPhase;
            end
          endcase
        end
      end
      xcs_pkg::StWait: begin
        if (acc) begin
          case (kind)
            xcs_pkg::KindTimeout: begin
              cmd_o.push_status = 1'b1;
              cmd_o.status      = xcs_pkg::StatTimeout;
            end
            xcs_pkg::KindResp: begin
              case (in_byte_value_i)
                xcs_pkg::ByteAck: begin
                  cmd_o.clr_block   = 1'b1;
                  cmd_o.push_status = 1'b1;
                  if (stat_i.final_pending) begin
                    cmd_o.clr_final = 1'b1;
                    cmd_o.eot       = 1'b1;
                    cmd_o.status    = xcs_pkg::StatFinished;
                  end
                end
                xcs_pkg::ByteNak: begin
                  if (stat_i.resends_zero) begin
                    cmd_o.push_status = 1'b1;
                    cmd_o.status      = xcs_pkg::StatNakLimit;
                  end else begin
                    cmd_o.dec_resend = 1'b1;
                    cmd_o.word_clr   = 1'b1;
                  end
                end
                xcs_pkg::ByteCan: begin
                  cmd_o.push_status = 1'b1;
                  cmd_o.status      = xcs_pkg::StatCanceled;
                end
                default: cmd_o.push_status = 1'b0;
              endcase
            end
            default: begin
              cmd_o.push_status = 1'b1;
              cmd_o.status      = xcs_pkg::StatPhase;
            end
          endcase
        end
      end
      xcs_pkg::StDone, xcs_pkg::StFail: begin
        if (acc) begin
          cmd_o.push_status = 1'b1;
          cmd_o.status      = xcs_pkg::StatPhase;
        end
      end
      xcs_pkg::StRead: cmd_o.read_en = 1'b1;
      xcs_pkg::StPush: cmd_o.push_frame = stat_i.can_load;
      default: cmd_o.read_en = 1'b0;
    endcase
  end

endmodule

>>> rtl/core/xcs_datapath.sv
module xcs_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [7:0]         cfg_retry_limit_i,
  input  logic [7:0]         in_byte_value_i,
  input  xcs_pkg::cmd_t      cmd_i,
  output xcs_pkg::stat_t     stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        out_frame_word_o,
  output logic [2:0]         out_byte_count_o,
  output logic               out_burst_end_o,
  output logic [2:0]         out_status_o
);

  localparam int unsigned FillW = xcs_pkg::FillW;
  localparam int unsigned WordW = xcs_pkg::WordW;
  localparam int unsigned RowW  = xcs_pkg::RowW;

  logic [7:0]       retry_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       bn_q, bn_d;
  logic [7:0]       resends_q, resends_d;
  logic             final_q, final_d;
  logic [WordW-1:0] word_q, word_d;
  logic [WordW-1:0] word_m1;
  logic [RowW-1:0]  rd_row [4];
  logic [7:0]       rdata_q [4];
  logic [7:0]       dat [4];
  logic [FillW-1:0] idx [4];
  logic [31:0]      frame_word;
  logic             word_first;

  logic             out_valid_q;
  logic [31:0]      out_word_q;
  logic [2:0]       out_count_q;
  logic             out_end_q;
  logic [2:0]       out_status_q;

  assign word_m1   = word_q - WordW'(1);
  assign rd_row[0] = word_q[RowW-1:0];
  assign idx[0]    = FillW'({word_q, 2'b00});

  for (genvar b = 1; b < 4; b++) begin : g_row
    assign rd_row[b] = word_m1[RowW-1:0];
    assign idx[b]    = FillW'({word_m1, 2'(b)});
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [xcs_pkg::RowDepth];

    always_ff @(posedge clk_i) begin
      if (cmd_i.wr_byte && (fill_q[1:0] == 2'(b))) begin
        mem[fill_q[RowW+1:2]] <= in_byte_value_i;
      end
      if (cmd_i.read_en) begin
        rdata_q[b] <= mem[rd_row[b]];
      end
    end

    assign dat[b] = (idx[b] < fill_q) ? rdata_q[b] : 8'h00;
  end

  assign word_first = (word_q == '0);

  always_comb begin
    frame_word[7:0]   = word_first ? xcs_pkg::ByteSoh : dat[1];
    frame_word[15:8]  = word_first ? bn_q : dat[2];
    frame_word[23:16] = word_first ? ~bn_q : dat[3];
    frame_word[31:24] = stat_o.word_last ? sum_q : dat[0];
  end

  always_comb begin
    fill_d    = fill_q;
    sum_d     = sum_q;
    bn_d      = bn_q;
    resends_d = resends_q;
    final_d   = final_q;
    word_d    = word_q;
    if (cmd_i.wr_byte) begin
      fill_d = fill_q + FillW'(1);
      sum_d  = sum_q + in_byte_value_i;
    end
    if (cmd_i.start_frame) begin
      resends_d = retry_q;
      final_d   = cmd_i.final_blk;
    end
    if (cmd_i.clr_block) begin
      fill_d = '0;
      sum_d  = '0;
      bn_d   = bn_q + 8'd1;
    end
    if (cmd_i.clr_final)  final_d   = 1'b0;
    if (cmd_i.dec_resend) resends_d = resends_q - 8'd1;
    if (cmd_i.word_clr)   word_d    = '0;
    if (cmd_i.push_frame) word_d    = stat_o.word_last ? '0 : word_q + WordW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q   <= xcs_pkg::RetryLimitRst;
      fill_q    <= '0;
      sum_q     <= '0;
      bn_q      <= xcs_pkg::BlockNumRst;
      resends_q <= xcs_pkg::RetryLimitRst;
      final_q   <= 1'b0;
      word_q    <= '0;
    end else begin
      if (cfg_valid_i) retry_q <= cfg_retry_limit_i;
      fill_q    <= fill_d;
      sum_q     <= sum_d;
      bn_q      <= bn_d;
      resends_q <= resends_d;
      final_q   <= final_d;
      word_q    <= word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_frame || cmd_i.push_status) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_frame) begin
      out_word_q   <= frame_word;
      out_count_q  <= 3'd4;
      out_end_q    <= stat_o.word_last;
      out_status_q <= xcs_pkg::StatSending;
    end else if (cmd_i.push_status) begin
      out_word_q   <= cmd_i.eot ? {24'h0, xcs_pkg::ByteEot} : 32'h0;
      out_count_q  <= cmd_i.eot ? 3'd1 : 3'd0;
      out_end_q    <= 1'b1;
      out_status_q <= cmd_i.status;
    end
  end

  assign stat_o.fill_last     = (fill_q == FillW'(xcs_pkg::BlockBytes - 1));
  assign stat_o.fill_empty    = (fill_q == '0);
  assign stat_o.final_pending = final_q;
  assign stat_o.resends_zero  = (resends_q == '0);
  assign stat_o.word_last     = (word_q == WordW'(xcs_pkg::FrameWords - 1));
  assign stat_o.out_busy      = out_valid_q;
  assign stat_o.can_load      = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign out_frame_word_o = out_word_q;
  assign out_byte_count_o = out_count_q;
  assign out_burst_end_o  = out_end_q;
  assign out_status_o     = out_status_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(xcs_pkg::BlockBytes))
    else $error("fill count past block size");

  a_word_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_q <= WordW'(xcs_pkg::FrameWords - 1))
    else $error("frame word index out of range");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_frame |-> (!out_valid_q || !out_stall_i))
    else $error("frame word overwrites pending result");

  a_status_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_status |-> !out_valid_q)
    else $error("status result overwrites pending result");

  a_push_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push_frame && cmd_i.push_status))
    else $error("two result sources at once");

endmodule

>>> rtl/core/xmodem_checksum_sender.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid / stall   | kind, byte_value
// out     | output    | out_valid / stall  | frame_word, byte_count, burst_end, status
// cfg     | input     | cfg_valid / ready  | retry_limit
//
// An input word is taken while in_stall_o is low; in_stall_o stays high while a result
// waits in the output register and while a frame is being sent.
// A frame is 33 words, each a buffer bank read (StRead) then an output load (StPush);
// the load waits while out_stall_i holds a pending result in the output register.
// The block buffer is four byte banks, one read per bank per frame word.
// rst_ni clears all control state at once; no clearing pass over the buffer.
module xmodem_checksum_sender (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_retry_limit_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_kind_i,
  input  logic [7:0]  in_byte_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_frame_word_o,
  output logic [2:0]  out_byte_count_o,
  output logic        out_burst_end_o,
  output logic [2:0]  out_status_o
);

  xcs_pkg::cmd_t  cmd;
  xcs_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  xcs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_kind_i       (in_kind_i),
    .in_byte_value_i (in_byte_value_i),
    .in_stall_o      (in_stall_o),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  xcs_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_retry_limit_i (cfg_retry_limit_i),
    .in_byte_value_i   (in_byte_value_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_frame_word_o  (out_frame_word_o),
    .out_byte_count_o  (out_byte_count_o),
    .out_burst_end_o   (out_burst_end_o),
    .out_status_o      (out_status_o)
  );

endmodule

>>> verif/xcs_checker.sv
`timescale 1ns / 1ps

module xcs_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_retry_limit_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  in_kind_i,
  input  logic [7:0]  in_byte_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] out_frame_word_i,
  input  logic [2:0]  out_byte_count_i,
  input  logic        out_burst_end_i,
  input  logic [2:0]  out_status_i,
  output int unsigned words_owed_o,
  output int unsigned errors_o
);

  typedef enum logic [1:0] {
    PhFill,
    PhWait,
    PhDone,
    PhFail
  } link_phase_e;

  typedef struct packed {
    logic [31:0]      word;
    logic [2:0]       count;
    logic             last;
    xcs_pkg::status_e status;
  } tx_word_t;

  tx_word_t    tx_due[$];
  logic [7:0]  blk_buf [xcs_pkg::BlockBytes];
  int unsigned fill;
  logic [7:0]  blk_num;
  logic [7:0]  sum;
  logic [7:0]  resends;
  logic [7:0]  retry_lim;
  logic        final_pend;
  link_phase_e phase;
  int unsigned errors;

  assign errors_o = errors;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [7:0] frame_byte(input int unsigned pos);
    if (pos == 0) return xcs_pkg::ByteSoh;
    if (pos == 1) return blk_num;
    if (pos == 2) return ~blk_num;
    if (pos == xcs_pkg::BlockBytes + 3) return sum;
    if (pos - 3 < fill) return blk_buf[pos - 3];
    return 8'h00;
  endfunction

  task automatic add_word(input logic [31:0] w, input logic [2:0] n, input logic last,
                          input xcs_pkg::status_e st);
    tx_due.push_back('{word: w, count: n, last: last, status: st});
  endtask

  task automatic queue_frame();
    logic [31:0] w;
    for (int i = 0; i < xcs_pkg::FrameWords; i++) begin
      for (int b = 0; b < 4; b++) begin
        w[8*b +: 8] = frame_byte(4 * i + b);
      end
      add_word(w, 3'd4, i == xcs_pkg::FrameWords - 1, xcs_pkg::StatSending);
    end
  endtask

  task automatic queue_eot();
    phase = PhDone;
    add_word({24'h0, xcs_pkg::ByteEot}, 3'd1, 1'b1, xcs_pkg::StatFinished);
  endtask

  task automatic start_frame(input logic is_final);
    final_pend = is_final;
    resends = retry_lim;
    phase = PhWait;
    queue_frame();
  endtask

  task automatic step_sender(input xcs_pkg::kind_e k, input logic [7:0] v);
    case (phase)
      PhFill: begin
        if (k == xcs_pkg::KindImage) begin
          blk_buf[fill] = v;
          fill++;
          sum = sum + v;
          if (fill >= xcs_pkg::BlockBytes) start_frame(1'b0);
        end else if (k == xcs_pkg::KindEnd) begin
          if (fill != 0) start_frame(1'b1);
          else queue_eot();
        end else begin
          add_word('0, 3'd0, 1'b1, xcs_pkg::StatPhase);
        end
      end
      PhWait: begin
        if (k == xcs_pkg::KindTimeout) begin
          phase = PhFail;
          add_word('0, 3'd0, 1'b1, xcs_pkg::StatTimeout);
        end else if (k != xcs_pkg::KindResp) begin
          add_word('0, 3'd0, 1'b1, xcs_pkg::StatPhase);
        end else if (v == xcs_pkg::ByteAck) begin
          blk_num = blk_num + 8'd1;
          fill = 0;
          sum = 8'h00;
          if (final_pend) begin
            final_pend = 1'b0;
            queue_eot();
          end else begin
            phase = PhFill;
            add_word('0, 3'd0, 1'b1, xcs_pkg::StatSending);
          end
        end else if (v == xcs_pkg::ByteNak) begin
          if (resends != 0) begin
            resends = resends - 8'd1;
            queue_frame();
          end else begin
            phase = PhFail;
            add_word('0, 3'd0, 1'b1, xcs_pkg::StatNakLimit);
          end
        end else if (v == xcs_pkg::ByteCan) begin
          phase = PhFail;
          add_word('0, 3'd0, 1'b1, xcs_pkg::StatCanceled);
        end
      end
      default: begin
        add_word('0, 3'd0, 1'b1, xcs_pkg::StatPhase);
      end
    endcase
  endtask

  task automatic check_word();
    tx_word_t exp;
    if (tx_due.size() == 0) begin
      flag_error($sformatf("unexpected word %h count %0d end %0b status %0d",
                           out_frame_word_i, out_byte_count_i, out_burst_end_i, out_status_i));
      return;
    end
    exp = tx_due.pop_front();
    if (out_frame_word_i !== exp.word)
      flag_error($sformatf("frame_word %h, want %h", out_frame_word_i, exp.word));
    if (out_byte_count_i !== exp.count)
      flag_error($sformatf("byte_count %0d, want %0d", out_byte_count_i, exp.count));
    if (out_burst_end_i !== exp.last)
      flag_error($sformatf("burst_end %0b, want %0b", out_burst_end_i, exp.last));
    if (out_status_i !== exp.status)
      flag_error($sformatf("status %0d, want %0d", out_status_i, exp.status));
  endtask

  initial errors = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_due.delete();
      fill = 0;
      blk_num = xcs_pkg::BlockNumRst;
      sum = 8'h00;
      retry_lim = xcs_pkg::RetryLimitRst;
      resends = xcs_pkg::RetryLimitRst;
      final_pend = 1'b0;
      phase = PhFill;
    end else begin
      if (cfg_valid_i && cfg_ready_i) retry_lim = cfg_retry_limit_i;
      if (in_valid_i && !in_stall_i) step_sender(xcs_pkg::kind_e'(in_kind_i), in_byte_value_i);
      if (out_valid_i && !out_stall_i) check_word();
    end
    words_owed_o <= tx_due.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned LongHold = 400;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [7:0]       cfg_retry_limit_i;
  logic             in_valid_i;
  logic             in_stall_o;
  xcs_pkg::kind_e   in_kind_i;
  logic [7:0]       in_byte_value_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [31:0]      out_frame_word_o;
  logic [2:0]       out_byte_count_o;
  logic             out_burst_end_o;
  logic [2:0]       out_status_o;

  int unsigned words_owed;
  int unsigned errors;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_req;
  int unsigned cycles;

  xmodem_checksum_sender u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_retry_limit_i(cfg_retry_limit_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_kind_i        (in_kind_i),
    .in_byte_value_i  (in_byte_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_frame_word_o (out_frame_word_o),
    .out_byte_count_o (out_byte_count_o),
    .out_burst_end_o  (out_burst_end_o),
    .out_status_o     (out_status_o)
  );

  xcs_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_retry_limit_i(cfg_retry_limit_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_kind_i        (in_kind_i),
    .in_byte_value_i  (in_byte_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_frame_word_i (out_frame_word_o),
    .out_byte_count_i (out_byte_count_o),
    .out_burst_end_i  (out_burst_end_o),
    .out_status_i     (out_status_o),
    .words_owed_o     (words_owed),
    .errors_o         (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // hold off for a requested stretch, else stall at random
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  task automatic send_word(input xcs_pkg::kind_e k, input logic [7:0] v);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i <= k;
    in_byte_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_owed != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_retry(input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_retry_limit_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic fill_block(input int unsigned n, input bit noisy);
    repeat (n) begin
      if (noisy && $urandom_range(0, 39) == 0) begin
        send_word($urandom_range(0, 1) ? xcs_pkg::KindResp : xcs_pkg::KindTimeout,
                  8'($urandom));
      end
      send_word(xcs_pkg::KindImage, 8'($urandom));
    end
  endtask

  initial begin
    int unsigned ending;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_retry_limit_i <= 8'h00;
    in_valid_i <= 1'b0;
    in_kind_i <= xcs_pkg::KindImage;
    in_byte_value_i <= 8'h00;
    hold_req = 0;
    snd_idle_pct = 18;
    rcv_idle_pct = 54;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_retry(8'd255);

    send_word(xcs_pkg::KindResp, xcs_pkg::ByteAck);
    send_word(xcs_pkg::KindTimeout, 8'h00);
    send_word(xcs_pkg::KindImage, 8'hFF);
    send_word(xcs_pkg::KindImage, 8'h00);
    fill_block(xcs_pkg::BlockBytes - 3, 1'b1);
    // back up the output so the next words stall at the input
    hold_req = LongHold;
    send_word(xcs_pkg::KindImage, 8'h5A);
    send_word(xcs_pkg::KindImage, 8'hA5);
    send_word(xcs_pkg::KindEnd, 8'hFF);
    send_word(xcs_pkg::KindResp, 8'h00);
    send_word(xcs_pkg::KindResp, 8'hFF);
    send_word(xcs_pkg::KindResp, xcs_pkg::ByteEot);
    send_word(xcs_pkg::KindResp, xcs_pkg::ByteSoh);
    send_word(xcs_pkg::KindResp, xcs_pkg::ByteNak);
    send_word(xcs_pkg::KindResp, xcs_pkg::ByteAck);
    drain();

    write_retry(8'd0);
    snd_idle_pct = 54;
    rcv_idle_pct = 18;
    ending = $urandom_range(0, 4);
    if (ending != 1) begin
      fill_block($urandom_range(1, 12), 1'b0);
    end
    send_word(xcs_pkg::KindEnd, 8'($urandom));
    case (ending)
      0: send_word(xcs_pkg::KindResp, xcs_pkg::ByteAck);
      2: send_word(xcs_pkg::KindResp, xcs_pkg::ByteCan);
      3: send_word(xcs_pkg::KindTimeout, 8'($urandom));
      4: send_word(xcs_pkg::KindResp, xcs_pkg::ByteNak);
      default: ;
    endcase

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (8) send_word(xcs_pkg::kind_e'($urandom_range(0, 3)), 8'($urandom));
    drain();

    if (errors == 0 && words_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
